@@ design/ipdd_pkg.sv @@
// shared types, timing windows and register codes of the ir pulse distance decoder
`default_nettype none

package ipdd_pkg;

  localparam int PULSE_W    = 16;
  localparam int KEY_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int LONG_FRAME_BITS_DEF  = 32;
  localparam int SHORT_FRAME_BITS_DEF = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PRODUCT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUSTOMER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd2;

  // inclusive pulse windows in microseconds
  typedef struct packed {
    logic [PULSE_W-1:0] mark_lo;
    logic [PULSE_W-1:0] mark_hi;
    logic [PULSE_W-1:0] space_lo;
    logic [PULSE_W-1:0] space_hi;
    logic [PULSE_W-1:0] zero_lo;
    logic [PULSE_W-1:0] zero_hi;
    logic [PULSE_W-1:0] one_lo;
    logic [PULSE_W-1:0] one_hi;
    logic [PULSE_W-1:0] clk_lo;
    logic [PULSE_W-1:0] clk_hi;
  } timing_t;

  localparam timing_t LONG_TIMING = '{
    mark_lo:  16'd7000, mark_hi:  16'd11000,
    space_lo: 16'd1500, space_hi: 16'd6000,
    zero_lo:  16'd400,  zero_hi:  16'd725,
    one_lo:   16'd929,  one_hi:   16'd2450,
    clk_lo:   16'd400,  clk_hi:   16'd720
  };

  localparam timing_t COMPACT_TIMING = '{
    mark_lo:  16'd778,  mark_hi:  16'd1222,
    space_lo: 16'd750,  space_hi: 16'd3000,
    zero_lo:  16'd357,  zero_hi:  16'd647,
    one_lo:   16'd962,  one_hi:   16'd2537,
    clk_lo:   16'd357,  clk_hi:   16'd643
  };

  // which windows one pulse falls into, polarity included
  typedef struct packed {
    logic mark;
    logic space;
    logic zero;
    logic one;
    logic clk;
  } pulse_hits_t;

  typedef struct packed {
    logic [7:0] product_code;
    logic [7:0] customer_code;
    logic       accept_enable;
  } cfg_t;

endpackage

`default_nettype wire

@@ design/ipdd_if.sv @@
// valid/ready channel interfaces for pulse items and key items
`default_nettype none

interface ipdd_pulse_if import ipdd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] pulse_width;
  logic               edge_polarity;

  modport source (output valid, pulse_width, edge_polarity, input ready);
  modport sink (input valid, pulse_width, edge_polarity, output ready);
endinterface

interface ipdd_key_if import ipdd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_code;
  logic             from_compact;

  modport source (output valid, key_code, from_compact, input ready);
  modport sink (input valid, key_code, from_compact, output ready);
endinterface

`default_nettype wire

@@ design/ipdd_classify.sv @@
// window compare of one pulse against one timing set
`default_nettype none

module ipdd_classify import ipdd_pkg::*; (
  input  logic [PULSE_W-1:0] pulse_width_i,
  input  logic               edge_polarity_i,
  input  timing_t            timing_i,
  output pulse_hits_t        hits_o
);

  logic neg;
  logic pos;

  assign neg = edge_polarity_i;
  assign pos = !edge_polarity_i;

  assign hits_o.mark  = neg && pulse_width_i >= timing_i.mark_lo
                            && pulse_width_i <= timing_i.mark_hi;
  assign hits_o.space = pos && pulse_width_i >= timing_i.space_lo
                            && pulse_width_i <= timing_i.space_hi;
  assign hits_o.zero  = pos && pulse_width_i >= timing_i.zero_lo
                            && pulse_width_i <= timing_i.zero_hi;
  assign hits_o.one   = pos && pulse_width_i >= timing_i.one_lo
                            && pulse_width_i <= timing_i.one_hi;
  assign hits_o.clk   = neg && pulse_width_i >= timing_i.clk_lo
                            && pulse_width_i <= timing_i.clk_hi;

endmodule

`default_nettype wire

@@ design/ipdd_core.sv @@
// four-phase frame machine, shift register and frame check
`default_nettype none

module ipdd_core import ipdd_pkg::*; #(
  parameter int LONG_FRAME_BITS  = LONG_FRAME_BITS_DEF,
  parameter int SHORT_FRAME_BITS = SHORT_FRAME_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  pulse_hits_t      hits_compact_i,
  input  pulse_hits_t      hits_long_i,
  input  cfg_t             cfg_i,
  output logic             result_valid_o,
  output logic [KEY_W-1:0] key_code_o,
  output logic             from_compact_o
);

  localparam int SHIFT_W = (LONG_FRAME_BITS > SHORT_FRAME_BITS) ?
                           LONG_FRAME_BITS : SHORT_FRAME_BITS;
  localparam int BITS_W  = $clog2(SHIFT_W + 1);

  localparam logic [1:0] PH_LEADER = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_CLOCK  = 2'd3;

  logic [1:0]         phase_q, phase_d;
  logic [SHIFT_W-1:0] shift_q, shift_d;
  logic [BITS_W-1:0]  bits_q, bits_d;
  logic               mode_q, mode_d;

  pulse_hits_t        sel;
  logic [BITS_W-1:0]  frame_bits;
  logic               done;
  logic [31:0]        frame;
  logic               key_ok;
  logic               compact_ok;
  logic               long_ok;

  always_comb begin
    phase_d    = phase_q;
    shift_d    = shift_q;
    bits_d     = bits_q;
    mode_d     = mode_q;
    done       = 1'b0;
    sel        = mode_q ? hits_compact_i : hits_long_i;
    frame_bits = mode_q ? BITS_W'(SHORT_FRAME_BITS) : BITS_W'(LONG_FRAME_BITS);
    unique case (phase_q)
      PH_LEADER: begin
        // compact mode falls back to the long leader on the same pulse
        if (mode_q && hits_compact_i.mark) begin
          phase_d = PH_FIRST;
        end else if (hits_long_i.mark) begin
          phase_d = PH_FIRST;
          mode_d  = 1'b0;
        end else begin
          mode_d  = 1'b1;
        end
      end
      PH_FIRST: begin
        if (sel.space) begin
          shift_d = '0;
          bits_d  = frame_bits;
          phase_d = PH_CLOCK;
        end else begin
          phase_d = PH_LEADER;
        end
      end
      PH_DATA: begin
        if (sel.zero || sel.one) begin
          shift_d = {shift_q[SHIFT_W-2:0], !sel.zero};
          bits_d  = bits_q - BITS_W'(1);
          phase_d = PH_CLOCK;
        end else begin
          phase_d = PH_LEADER;
        end
      end
      PH_CLOCK: begin
        if (sel.clk && bits_q != '0) begin
          phase_d = PH_DATA;
        end else begin
          done    = sel.clk;
          phase_d = PH_LEADER;
          bits_d  = '0;
        end
      end
    endcase
  end

  assign frame      = 32'(shift_q);
  assign key_ok     = frame[7:0] == ~frame[15:8];
  assign compact_ok = key_ok;
  assign long_ok    = key_ok && frame[23:16] == cfg_i.product_code
                      && frame[31:24] == cfg_i.customer_code && cfg_i.accept_enable;

  assign result_valid_o = step_i && done && (mode_q ? compact_ok : long_ok);
  assign key_code_o     = frame[7:0];
  assign from_compact_o = mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEADER;
      shift_q <= '0;
      bits_q  <= '0;
      mode_q  <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      mode_q  <= mode_d;
    end
  end

endmodule

`default_nettype wire

@@ design/ir_pulse_distance_decoder.sv @@
// top level of the ir pulse distance decoder: input stage, decode, result stage
// output: a validated key item enters the result register once the closing clock pulse steps out of the input register
// throughput: one pulse item per cycle unless a waiting key item stalls the input, set by the phase machine update
// a waiting key item stalls the input once the input register holds an item
// reset: async active low, clears phase, shift word and bit count, selects compact
// mode and loads the registers with product 0, customer 0, accept_enable 1
`default_nettype none

module ir_pulse_distance_decoder import ipdd_pkg::*; #(
  parameter int LONG_FRAME_BITS  = LONG_FRAME_BITS_DEF,
  parameter int SHORT_FRAME_BITS = SHORT_FRAME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ipdd_pulse_if.sink            pulse_i,
  ipdd_key_if.source            key_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // configuration registers
  cfg_t cfg_q;

  // input stage
  logic               in_valid_q;
  logic [PULSE_W-1:0] width_q;
  logic               pol_q;

  // result stage
  logic               out_valid_q;
  logic [KEY_W-1:0]   key_q;
  logic               compact_q;

  logic               step;
  logic               in_ready;
  pulse_hits_t        hits_compact;
  pulse_hits_t        hits_long;
  logic               result_valid;
  logic [KEY_W-1:0]   result_key;
  logic               result_compact;

  // the buffered item moves on once the result slot is free or draining
  assign step     = in_valid_q && (!out_valid_q || key_o.ready);
  assign in_ready = !in_valid_q || step;

  assign pulse_i.ready      = in_ready;
  assign key_o.valid        = out_valid_q;
  assign key_o.key_code     = key_q;
  assign key_o.from_compact = compact_q;

  // register writes, index beyond the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.product_code  <= 8'd0;
      cfg_q.customer_code <= 8'd0;
      cfg_q.accept_enable <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PRODUCT:  cfg_q.product_code  <= cfg_wdata_i[7:0];
        REG_CUSTOMER: cfg_q.customer_code <= cfg_wdata_i[7:0];
        REG_ENABLE:   cfg_q.accept_enable <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= pulse_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pulse_i.valid && in_ready) begin
      width_q <= pulse_i.pulse_width;
      pol_q   <= pulse_i.edge_polarity;
    end
  end

  // both timing sets are compared at once, the leader may need both
  ipdd_classify u_classify_compact (
    .pulse_width_i   (width_q),
    .edge_polarity_i (pol_q),
    .timing_i        (COMPACT_TIMING),
    .hits_o          (hits_compact)
  );

  ipdd_classify u_classify_long (
    .pulse_width_i   (width_q),
    .edge_polarity_i (pol_q),
    .timing_i        (LONG_TIMING),
    .hits_o          (hits_long)
  );

  ipdd_core #(
    .LONG_FRAME_BITS  (LONG_FRAME_BITS),
    .SHORT_FRAME_BITS (SHORT_FRAME_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .hits_compact_i (hits_compact),
    .hits_long_i    (hits_long),
    .cfg_i          (cfg_q),
    .result_valid_o (result_valid),
    .key_code_o     (result_key),
    .from_compact_o (result_compact)
  );

  // result register, loaded only by a validated frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || key_o.ready) begin
      out_valid_q <= result_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_valid) begin
      key_q     <= result_key;
      compact_q <= result_compact;
    end
  end

endmodule

`default_nettype wire

@@ design/ipdd_checker.sv @@
// port-level assertions of the ir pulse distance decoder and their bind
`default_nettype none

module ipdd_checker import ipdd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [KEY_W-1:0] key_code_i,
  input logic             from_compact_i
);

  // a key item waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("key item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(key_code_i) && $stable(from_compact_i))
    else $error("key item changed while stalled");

  // with the result slot free or draining the input side never stalls
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input stalled with result slot free");

  // a frame spans many pulses, so two keys never follow one another directly
  a_key_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> !out_valid_i)
    else $error("key items back to back");

endmodule

bind ir_pulse_distance_decoder ipdd_checker u_ipdd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (pulse_i.ready),
  .out_valid_i    (key_o.valid),
  .out_ready_i    (key_o.ready),
  .key_code_i     (key_o.key_code),
  .from_compact_i (key_o.from_compact)
);

`default_nettype wire

@@ tb/sv/ir_pulse_distance_decoder_tb.sv @@
// self-checking testbench of the ir pulse distance decoder: random ir frames, predicted keys
`default_nettype none

module ir_pulse_distance_decoder_tb;
  import ipdd_pkg::*;

  // stimulus sizing: pulse items per idling phase, and keys wanted per phase
  localparam int ITEMS_PER_PHASE = 480;
  localparam int KEYS_PER_PHASE  = 12;
  // cycles with work pending but no handshake on either side before giving up
  localparam int STALL_LIMIT     = 5000;
  // settle time after the last key, longer than the latency of the block
  localparam int SETTLE_CYCLES   = 4;
  localparam int TAIL_CYCLES     = 8;

  // phases of the decode machine, one machine shared by both formats
  typedef enum logic [1:0] {
    WAIT_LEADER,
    WAIT_FIRST_CLOCK,
    WAIT_DATA,
    WAIT_CLOCK_END
  } dec_phase_e;

  // inclusive pulse windows in microseconds plus the data bit count of a format
  typedef struct packed {
    logic [15:0] mark_lo;
    logic [15:0] mark_hi;
    logic [15:0] space_lo;
    logic [15:0] space_hi;
    logic [15:0] zero_lo;
    logic [15:0] zero_hi;
    logic [15:0] one_lo;
    logic [15:0] one_hi;
    logic [15:0] clk_lo;
    logic [15:0] clk_hi;
    logic [5:0]  nbits;
  } window_set_t;

  localparam window_set_t LONG_WIN = '{
    16'd7000, 16'd11000, 16'd1500, 16'd6000, 16'd400, 16'd725,
    16'd929, 16'd2450, 16'd400, 16'd720, 6'd32
  };
  localparam window_set_t COMPACT_WIN = '{
    16'd778, 16'd1222, 16'd750, 16'd3000, 16'd357, 16'd647,
    16'd962, 16'd2537, 16'd357, 16'd643, 6'd16
  };

  typedef struct packed {
    logic [PULSE_W-1:0] width;
    logic               pol;
  } pulse_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             compact;
  } key_item_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  // locally held drive values, known from time zero
  logic                  pulse_valid = 1'b0;
  logic [PULSE_W-1:0]    pulse_width = '0;
  logic                  pulse_pol   = 1'b0;
  logic                  key_ready   = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = REG_PRODUCT;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

  // idling of the two sides, in percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  ipdd_pulse_if pulse_bus ();
  ipdd_key_if   key_bus ();

  assign pulse_bus.valid         = pulse_valid;
  assign pulse_bus.pulse_width   = pulse_width;
  assign pulse_bus.edge_polarity = pulse_pol;
  assign key_bus.ready           = key_ready;

  ir_pulse_distance_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pulse_i     (pulse_bus),
    .key_o       (key_bus),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  // pulses waiting to be driven, and keys the decoder still owes us
  pulse_item_t pending_pulses[$];
  key_item_t   expected_keys[$];

  int unsigned pulses_queued  = 0;
  int unsigned keys_predicted = 0;
  int unsigned mismatches     = 0;

  // shadow of the decoder state and its registers
  dec_phase_e  dec_phase     = WAIT_LEADER;
  logic [31:0] rx_word       = '0;
  logic [5:0]  bits_to_go    = '0;
  logic        compact_first = 1'b1;
  logic [7:0]  product_reg   = 8'h00;
  logic [7:0]  customer_reg  = 8'h00;
  logic        enable_reg    = 1'b1;

  function automatic bit in_window(logic [15:0] wd, logic pol, logic [15:0] lo,
                                   logic [15:0] hi, logic want);
    return (pol == want) && (wd >= lo) && (wd <= hi);
  endfunction

  // one step of the shared machine under one format's windows
  // returns 1 on a leader miss, frame_done is set by the clock after the last bit
  function automatic bit step_machine(window_set_t win, logic [15:0] wd, logic pol,
                                      output bit frame_done);
    bit leader_miss;
    leader_miss = 1'b0;
    frame_done  = 1'b0;
    case (dec_phase)
      WAIT_LEADER: begin
        if (in_window(wd, pol, win.mark_lo, win.mark_hi, 1'b1)) dec_phase = WAIT_FIRST_CLOCK;
        else leader_miss = 1'b1;
      end
      WAIT_FIRST_CLOCK: begin
        if (in_window(wd, pol, win.space_lo, win.space_hi, 1'b0)) begin
          rx_word    = '0;
          bits_to_go = win.nbits;
          dec_phase  = WAIT_CLOCK_END;
        end else begin
          dec_phase = WAIT_LEADER;
        end
      end
      WAIT_DATA: begin
        if (in_window(wd, pol, win.zero_lo, win.zero_hi, 1'b0)) begin
          rx_word    = {rx_word[30:0], 1'b0};
          bits_to_go = bits_to_go - 6'd1;
          dec_phase  = WAIT_CLOCK_END;
        end else if (in_window(wd, pol, win.one_lo, win.one_hi, 1'b0)) begin
          rx_word    = {rx_word[30:0], 1'b1};
          bits_to_go = bits_to_go - 6'd1;
          dec_phase  = WAIT_CLOCK_END;
        end else begin
          dec_phase = WAIT_LEADER;
        end
      end
      default: begin
        if (in_window(wd, pol, win.clk_lo, win.clk_hi, 1'b1)) begin
          if (bits_to_go != 6'd0) begin
            dec_phase = WAIT_DATA;
          end else begin
            frame_done = 1'b1;
            dec_phase  = WAIT_LEADER;
            bits_to_go = '0;
          end
        end else begin
          // a bad clock pulse also drops the bit count
          dec_phase  = WAIT_LEADER;
          bits_to_go = '0;
        end
      end
    endcase
    return leader_miss;
  endfunction

  // predicts the key item, if any, caused by one accepted pulse item
  function automatic void decode_pulse(logic [15:0] wd, logic pol);
    bit        done;
    key_item_t k;
    if (compact_first) begin
      // a compact leader miss falls through to the long leader with the same pulse
      if (step_machine(COMPACT_WIN, wd, pol, done)) begin
        compact_first = 1'b0;
      end else if (done && rx_word[7:0] == ~rx_word[15:8]) begin
        k.key     = rx_word[7:0];
        k.compact = 1'b1;
        expected_keys.push_back(k);
        keys_predicted++;
      end
    end
    if (!compact_first) begin
      // a long leader miss only re-arms compact mode, no retry
      if (step_machine(LONG_WIN, wd, pol, done)) begin
        compact_first = 1'b1;
      end else if (done && rx_word[7:0] == ~rx_word[15:8] &&
                   rx_word[23:16] == product_reg && rx_word[31:24] == customer_reg &&
                   enable_reg) begin
        k.key     = rx_word[7:0];
        k.compact = 1'b0;
        expected_keys.push_back(k);
        keys_predicted++;
      end
    end
  endfunction

  function automatic pulse_item_t make_pulse(logic [15:0] wd, logic pol);
    pulse_item_t p;
    p.width = wd;
    p.pol   = pol;
    return p;
  endfunction

  // a width inside a window, with the window edges hit often
  function automatic logic [15:0] pick_in(logic [15:0] lo, logic [15:0] hi);
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return hi;
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  // a pulse of random width and polarity, saturated widths included
  function automatic pulse_item_t noise_pulse();
    logic [15:0] wd;
    case ($urandom_range(0, 4))
      0:       wd = 16'hFFFF;
      1:       wd = 16'($urandom_range(3000, 0));
      2:       wd = 16'($urandom_range(12000, 3000));
      default: wd = 16'($urandom);
    endcase
    return make_pulse(wd, 1'($urandom_range(1, 0)));
  endfunction

  task automatic queue_pulse(logic [15:0] wd, logic pol);
    pending_pulses.push_back(make_pulse(wd, pol));
    pulses_queued++;
  endtask

  // builds leader, space and first clock, then data and clock per bit, msb first
  // damage 1 swaps one pulse for noise, damage 2 also cuts the frame off there
  task automatic queue_frame(bit compact, logic [31:0] word, int damage);
    window_set_t win;
    pulse_item_t seq[$];
    int          pos;
    win = compact ? COMPACT_WIN : LONG_WIN;
    seq.push_back(make_pulse(pick_in(win.mark_lo, win.mark_hi), 1'b1));
    seq.push_back(make_pulse(pick_in(win.space_lo, win.space_hi), 1'b0));
    seq.push_back(make_pulse(pick_in(win.clk_lo, win.clk_hi), 1'b1));
    for (int i = int'(win.nbits) - 1; i >= 0; i--) begin
      if (word[i]) seq.push_back(make_pulse(pick_in(win.one_lo, win.one_hi), 1'b0));
      else seq.push_back(make_pulse(pick_in(win.zero_lo, win.zero_hi), 1'b0));
      seq.push_back(make_pulse(pick_in(win.clk_lo, win.clk_hi), 1'b1));
    end
    if (damage != 0) begin
      pos      = $urandom_range(seq.size() - 1, 0);
      seq[pos] = noise_pulse();
      if (damage == 2) begin
        while (seq.size() > pos + 1) void'(seq.pop_back());
      end
    end
    foreach (seq[i]) pending_pulses.push_back(seq[i]);
    pulses_queued += seq.size();
  endtask

  // returns once nothing is queued, in flight or owed, plus a settle gap
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_pulses.size() != 0 || pulse_valid || expected_keys.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write, only called while the decoder is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_PRODUCT:  product_reg  = data;
      REG_CUSTOMER: customer_reg = data;
      REG_ENABLE:   enable_reg   = data[0];
      default:      ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // pulse driver: predicts each accepted item, then offers the next one or idles
  always @(posedge clk_i) begin : pulse_driver
    pulse_item_t next_pulse;
    if (rst_ni) begin
      if (pulse_valid && pulse_bus.ready) decode_pulse(pulse_width, pulse_pol);
      if (!pulse_valid || pulse_bus.ready) begin
        if (pending_pulses.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          next_pulse  = pending_pulses.pop_front();
          pulse_valid <= 1'b1;
          pulse_width <= next_pulse.width;
          pulse_pol   <= next_pulse.pol;
        end else begin
          pulse_valid <= 1'b0;
        end
      end
    end
  end

  // key monitor: compares each accepted key item with the oldest prediction
  always @(posedge clk_i) begin : key_monitor
    key_item_t want;
    if (rst_ni) begin
      if (key_bus.valid && key_ready) begin
        if (expected_keys.size() == 0) begin
          $display("%0t: unexpected key item: key %02h from_compact %0b", $time,
                   key_bus.key_code, key_bus.from_compact);
          mismatches++;
        end else begin
          want = expected_keys.pop_front();
          if (key_bus.key_code !== want.key || key_bus.from_compact !== want.compact) begin
            $display({"%0t: key item mismatch: expected key %02h from_compact %0b,",
                      " got key %02h from_compact %0b"},
                     $time, want.key, want.compact, key_bus.key_code, key_bus.from_compact);
            mismatches++;
          end
        end
      end
      key_ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // watchdog: counts cycles with work pending and no handshake anywhere
  always @(posedge clk_i) begin : watchdog
    int unsigned stuck_cycles;
    if ((pulse_valid && pulse_bus.ready) || (key_bus.valid && key_ready) ||
        !(pending_pulses.size() != 0 || pulse_valid || expected_keys.size() != 0)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d key items outstanding", $time,
               stuck_cycles, expected_keys.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase_start;
    int unsigned keys_start;
    bit          paused;
    int unsigned choice;
    bit          compact;
    logic [7:0]  key;
    logic [7:0]  inv;
    logic [7:0]  prod;
    logic [7:0]  cust;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      // one register setting and one idling pattern per phase
      case (ph)
        0: begin
          write_reg(REG_PRODUCT, 8'h00);
          write_reg(REG_CUSTOMER, 8'hFF);
          write_reg(REG_ENABLE, 8'h01);
          send_idle_pct <= 0;
          stall_pct     <= 0;
        end
        1: begin
          write_reg(REG_PRODUCT, 8'hFF);
          write_reg(REG_CUSTOMER, 8'h00);
          write_reg(REG_ENABLE, 8'h01);
          send_idle_pct <= 84;
          stall_pct     <= 0;
        end
        2: begin
          // long keys muted, compact keys still reported
          write_reg(REG_PRODUCT, 8'($urandom_range(255, 0)));
          write_reg(REG_CUSTOMER, 8'($urandom_range(255, 0)));
          write_reg(REG_ENABLE, 8'h00);
          send_idle_pct <= 0;
          stall_pct     <= 84;
        end
        default: begin
          write_reg(REG_PRODUCT, 8'($urandom_range(255, 0)));
          write_reg(REG_CUSTOMER, 8'($urandom_range(255, 0)));
          write_reg(REG_ENABLE, 8'h01);
          send_idle_pct <= 37;
          stall_pct     <= 37;
        end
      endcase

      if (ph == 0) begin
        // width extremes with both polarities, misses in compact mode
        queue_pulse(16'd0, 1'b0);
        queue_pulse(16'hFFFF, 1'b1);
        queue_pulse(16'hFFFF, 1'b0);
        queue_pulse(16'd0, 1'b1);
        queue_pulse(16'd777, 1'b1);
        queue_pulse(16'd1223, 1'b1);
        // compact leader, then a bad space mid-frame
        queue_pulse(16'd778, 1'b1);
        queue_pulse(16'd749, 1'b0);
        // compact leader and space, then a clock just too long
        queue_pulse(16'd1222, 1'b1);
        queue_pulse(16'd3000, 1'b0);
        queue_pulse(16'd644, 1'b1);
        // long leader via the compact miss, then a bad data pulse, mode kept long
        queue_pulse(16'd7000, 1'b1);
        queue_pulse(16'd1500, 1'b0);
        queue_pulse(16'd400, 1'b1);
        queue_pulse(16'd2451, 1'b0);
        // long leader miss re-arms compact mode without a retry
        queue_pulse(16'd11001, 1'b1);
        queue_pulse(16'd11000, 1'b1);
        queue_pulse(16'd6001, 1'b0);
        queue_pulse(16'd6999, 1'b1);
        // compact frame start with a one bit, then a clock in the long window only
        queue_pulse(16'd1000, 1'b1);
        queue_pulse(16'd750, 1'b0);
        queue_pulse(16'd357, 1'b1);
        queue_pulse(16'd962, 1'b0);
        queue_pulse(16'd720, 1'b1);
        queue_pulse(16'h8000, 1'b1);
      end

      phase_start = pulses_queued;
      keys_start  = keys_predicted;
      paused      = 1'b0;
      while (((pulses_queued - phase_start) < ITEMS_PER_PHASE ||
              (keys_predicted - keys_start) < KEYS_PER_PHASE) &&
             (pulses_queued - phase_start) < 4 * ITEMS_PER_PHASE) begin
        choice  = $urandom_range(99, 0);
        compact = 1'($urandom_range(1, 0));
        key     = 8'($urandom_range(255, 0));
        // mostly a matching inverse byte so that many frames validate
        inv     = ($urandom_range(3, 0) != 0) ? ~key : 8'($urandom_range(255, 0));
        prod    = ($urandom_range(6, 0) != 0) ? product_reg : 8'($urandom_range(255, 0));
        cust    = ($urandom_range(6, 0) != 0) ? customer_reg : 8'($urandom_range(255, 0));
        if (choice < 85 && compact && $urandom_range(4, 0) < 3) begin
          // a short junk pulse ends any frame; at the leader it selects compact mode
          queue_pulse(16'($urandom_range(356, 0)), 1'b0);
        end
        if (choice < 70) begin
          queue_frame(compact, compact ? {16'h0000, inv, key} : {cust, prod, inv, key}, 0);
        end else if (choice < 85) begin
          queue_frame(compact, compact ? {16'h0000, inv, key} : {cust, prod, inv, key},
                      $urandom_range(2, 1));
        end else begin
          repeat ($urandom_range(3, 1)) begin
            pending_pulses.push_back(noise_pulse());
            pulses_queued++;
          end
        end
        // halfway through, hold the sender until every owed key is out
        if (!paused && (pulses_queued - phase_start) >= ITEMS_PER_PHASE / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        while (pending_pulses.size() > 8) @(posedge clk_i);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_keys.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (expected_keys.size() != 0)
        $display("%0t: %0d predicted key items never arrived", $time, expected_keys.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
